### src/cdp_pkg.sv
package cdp_pkg;

    localparam int CB_ENTRIES    = 8;
    localparam int CB_IDX_W      = 3;
    localparam int FIELD_LANES   = 4;
    localparam int DEFAULT_LANES = 4;

    localparam int QUERY_W = 16;
    localparam int CENT_W  = 16;
    localparam int PLANE_W = 4;
    localparam int PROD_W  = QUERY_W + CENT_W;
    localparam int ACC_W   = 40;
    localparam int SUM_W   = ACC_W + 3;
    localparam int NORM_W  = 32;
    localparam int HALF_W  = NORM_W / 2;
    localparam int PART_W  = ACC_W + HALF_W;
    localparam int FULL_W  = ACC_W + NORM_W;
    localparam int FRAC_SH = 29;
    localparam int MAG_W   = FULL_W - FRAC_SH;
    localparam int SCORE_W = 48;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 48;

    localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(((64'sd1) <<< (ACC_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

    typedef logic signed [CENT_W-1:0] t_codebook [CB_ENTRIES];

    // finished accumulation handed from the merge stage to the scaling unit
    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] acc;
        logic                    clip;
        logic [NORM_W-1:0]       norm;
    } t_final;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_HIGH,
        SC_LOW,
        SC_SUM,
        SC_PACK
    } t_scale_state;

endpackage

### src/codebook_dot_product_unit.sv
// path: lane product regs, merge result regs, scaling states IDLE, HIGH, LOW, SUM, PACK
// throughput: one group per cycle inside a vector; after a last group the slave side
//   holds tready low until the score reaches the output register; the wait is set by
//   the norm multiply, split into two 40x16 partial products on separate cycles, plus
//   any master-side stall
// reset: synchronous, active low; clears codebook, accumulator, clip flag and valids
module codebook_dot_product_unit #(
    parameter int LANES = cdp_pkg::DEFAULT_LANES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    // config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cdp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cdp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cdp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,

    // group stream in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // query_a[15:0], query_b[31:16], query_c[47:32], query_d[63:48],
    // plane_low[67:64], plane_mid[71:68], plane_high[75:72], key_norm[107:76], zero pad
    input  logic [cdp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                               s_axis_tlast,   // final_group

    // score stream out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [cdp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // score[47:0]
    output logic [0:0]                         m_axis_tuser    // saturated
);

    // only four query elements travel per group, extra lanes would sit idle
    localparam int ACTIVE = (LANES < cdp_pkg::FIELD_LANES) ? LANES : cdp_pkg::FIELD_LANES;

    localparam int PLANE_LOW_LSB  = cdp_pkg::FIELD_LANES * cdp_pkg::QUERY_W;
    localparam int PLANE_MID_LSB  = PLANE_LOW_LSB + cdp_pkg::PLANE_W;
    localparam int PLANE_HIGH_LSB = PLANE_MID_LSB + cdp_pkg::PLANE_W;
    localparam int NORM_LSB       = PLANE_HIGH_LSB + cdp_pkg::PLANE_W;

    cdp_pkg::t_codebook                 r_codebook;
    logic                               r_busy;
    logic                               r_stage_valid;
    logic                               r_stage_last;
    logic [cdp_pkg::NORM_W-1:0]         r_stage_norm;

    logic                               s_xfer;
    logic                               cfg_write;
    logic [cdp_pkg::CB_IDX_W-1:0]       cfg_index;
    logic signed [cdp_pkg::PROD_W-1:0]  products [ACTIVE];
    cdp_pkg::t_final                    fin;
    logic                               score_done;
    logic signed [cdp_pkg::SCORE_W-1:0] score;
    logic                               saturated;

    // ---------------------------------------------------------------
    // codebook registers, word address = entry index
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[cdp_pkg::CB_IDX_W+1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < cdp_pkg::CB_ENTRIES; e++) begin
                r_codebook[e] <= '0;
            end
        end else if (cfg_write) begin
            r_codebook[cfg_index] <= pwdata[cdp_pkg::CENT_W-1:0];
        end
    end

    // read back sign extended
    assign prdata = cdp_pkg::APB_DATA_W'(r_codebook[cfg_index]);

    // ---------------------------------------------------------------
    // input side: groups stream freely until a last group is taken,
    // then wait for its score to land in the output register
    // ---------------------------------------------------------------
    assign s_axis_tready = !r_busy;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_stage_valid <= 1'b0;
            r_stage_last  <= 1'b0;
        end else begin
            r_stage_valid <= s_xfer;
            r_stage_last  <= s_xfer && s_axis_tlast;
            if (s_xfer && s_axis_tlast) begin
                r_busy <= 1'b1;
            end else if (score_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // norm rides along with the lane products
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_stage_norm <= s_axis_tdata[NORM_LSB +: cdp_pkg::NORM_W];
        end
    end

    // ---------------------------------------------------------------
    // lanes: index rebuild, centroid lookup, multiply
    // ---------------------------------------------------------------
    for (genvar k = 0; k < ACTIVE; k++) begin : g_lane
        cdp_lane u_lane (
            .i_clk      (i_clk),
            .i_en       (s_xfer),
            .i_query    (s_axis_tdata[k*cdp_pkg::QUERY_W +: cdp_pkg::QUERY_W]),
            .i_bit_low  (s_axis_tdata[PLANE_LOW_LSB + k]),
            .i_bit_mid  (s_axis_tdata[PLANE_MID_LSB + k]),
            .i_bit_high (s_axis_tdata[PLANE_HIGH_LSB + k]),
            .i_codebook (r_codebook),
            .o_product  (products[k])
        );
    end

    // ---------------------------------------------------------------
    // merge: lane sum into the saturating accumulator
    // ---------------------------------------------------------------
    cdp_merge #(
        .NUM_LANES (ACTIVE)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_stage_valid),
        .i_last     (r_stage_last),
        .i_norm     (r_stage_norm),
        .i_products (products),
        .o_final    (fin)
    );

    // ---------------------------------------------------------------
    // norm scaling, rounding and output register
    // ---------------------------------------------------------------
    cdp_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_final     (fin),
        .i_tready    (m_axis_tready),
        .o_tvalid    (m_axis_tvalid),
        .o_score     (score),
        .o_saturated (saturated),
        .o_done      (score_done)
    );

    assign m_axis_tdata = score;
    assign m_axis_tuser = saturated;

endmodule

### src/cdp_lane.sv
module cdp_lane (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [cdp_pkg::QUERY_W-1:0]   i_query,
    input  logic                                 i_bit_low,
    input  logic                                 i_bit_mid,
    input  logic                                 i_bit_high,
    input  cdp_pkg::t_codebook                   i_codebook,
    output logic signed [cdp_pkg::PROD_W-1:0]    o_product
);

    logic [cdp_pkg::CB_IDX_W-1:0]       index;
    logic signed [cdp_pkg::CENT_W-1:0]  centroid;
    logic signed [cdp_pkg::PROD_W-1:0]  r_product;

    assign index    = {i_bit_high, i_bit_mid, i_bit_low};
    assign centroid = i_codebook[index];

    // Q2.14 times Q1.15 gives Q3.29
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_product <= i_query * centroid;
        end
    end

    assign o_product = r_product;

endmodule

### src/cdp_merge.sv
module cdp_merge #(
    parameter int NUM_LANES = cdp_pkg::DEFAULT_LANES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_last,
    input  logic [cdp_pkg::NORM_W-1:0]          i_norm,
    input  logic signed [cdp_pkg::PROD_W-1:0]   i_products [NUM_LANES],
    output cdp_pkg::t_final                     o_final
);

    logic signed [cdp_pkg::ACC_W-1:0]  r_acc;
    logic                              r_clip;
    logic                              r_fin_valid;
    logic signed [cdp_pkg::ACC_W-1:0]  r_fin_acc;
    logic                              r_fin_clip;
    logic [cdp_pkg::NORM_W-1:0]        r_fin_norm;

    logic signed [cdp_pkg::SUM_W-1:0]  sum;
    logic signed [cdp_pkg::ACC_W-1:0]  n_acc;
    logic                              overflow;

    always_comb begin
        sum = cdp_pkg::SUM_W'(r_acc);
        for (int k = 0; k < NUM_LANES; k++) begin
            sum = sum + cdp_pkg::SUM_W'(i_products[k]);
        end
        overflow = 1'b1;
        if (sum > cdp_pkg::ACC_MAX) begin
            n_acc = cdp_pkg::ACC_W'(cdp_pkg::ACC_MAX);
        end else if (sum < cdp_pkg::ACC_MIN) begin
            n_acc = cdp_pkg::ACC_W'(cdp_pkg::ACC_MIN);
        end else begin
            n_acc    = sum[cdp_pkg::ACC_W-1:0];
            overflow = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_clip      <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= i_valid && i_last;
            if (i_valid) begin
                if (i_last) begin
                    r_acc  <= '0;
                    r_clip <= 1'b0;
                end else begin
                    r_acc  <= n_acc;
                    r_clip <= r_clip || overflow;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_last) begin
            r_fin_acc  <= n_acc;
            r_fin_clip <= r_clip || overflow;
            r_fin_norm <= i_norm;
        end
    end

    assign o_final = '{valid: r_fin_valid, acc: r_fin_acc, clip: r_fin_clip, norm: r_fin_norm};

endmodule

### src/cdp_scale.sv
module cdp_scale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cdp_pkg::t_final                      i_final,
    input  logic                                 i_tready,
    output logic                                 o_tvalid,
    output logic signed [cdp_pkg::SCORE_W-1:0]   o_score,
    output logic                                 o_saturated,
    output logic                                 o_done
);

    cdp_pkg::t_scale_state              r_state;
    cdp_pkg::t_scale_state              n_state;

    logic [cdp_pkg::ACC_W-1:0]          r_mag;
    logic                               r_neg;
    logic                               r_clip;
    logic [cdp_pkg::NORM_W-1:0]         r_norm;
    logic [cdp_pkg::PART_W-1:0]         r_phi;
    logic [cdp_pkg::PART_W-1:0]         r_plo;
    logic [cdp_pkg::MAG_W-1:0]          r_q;
    logic                               r_out_valid;
    logic signed [cdp_pkg::SCORE_W-1:0] r_score;
    logic                               r_sat;

    logic [cdp_pkg::PART_W-1:0]         n_phi;
    logic [cdp_pkg::PART_W-1:0]         n_plo;
    logic [cdp_pkg::FULL_W-1:0]         total;
    logic [cdp_pkg::SCORE_W-1:0]        q_ext;
    logic                               load_out;

    assign n_phi = r_mag * r_norm[cdp_pkg::NORM_W-1:cdp_pkg::HALF_W];
    assign n_plo = r_mag * r_norm[cdp_pkg::HALF_W-1:0];
    // rounding constant is half an lsb of the Q16.16 result
    assign total = {r_phi, cdp_pkg::HALF_W'(0)} + cdp_pkg::FULL_W'(r_plo)
                 + (cdp_pkg::FULL_W'(1) << (cdp_pkg::FRAC_SH - 1));
    assign q_ext = cdp_pkg::SCORE_W'(r_q);

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            cdp_pkg::SC_IDLE: begin
                if (i_final.valid) begin
                    n_state = cdp_pkg::SC_HIGH;
                end
            end
            cdp_pkg::SC_HIGH: n_state = cdp_pkg::SC_LOW;
            cdp_pkg::SC_LOW:  n_state = cdp_pkg::SC_SUM;
            cdp_pkg::SC_SUM:  n_state = cdp_pkg::SC_PACK;
            cdp_pkg::SC_PACK: begin
                if (!r_out_valid || i_tready) begin
                    load_out = 1'b1;
                    n_state  = cdp_pkg::SC_IDLE;
                end
            end
            default: n_state = cdp_pkg::SC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdp_pkg::SC_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cdp_pkg::SC_IDLE && i_final.valid) begin
            r_neg  <= i_final.acc[cdp_pkg::ACC_W-1];
            r_mag  <= i_final.acc[cdp_pkg::ACC_W-1] ? cdp_pkg::ACC_W'(-i_final.acc)
                                                   : cdp_pkg::ACC_W'(i_final.acc);
            r_clip <= i_final.clip;
            r_norm <= i_final.norm;
        end
        if (r_state == cdp_pkg::SC_HIGH) begin
            r_phi <= n_phi;
        end
        if (r_state == cdp_pkg::SC_LOW) begin
            r_plo <= n_plo;
        end
        if (r_state == cdp_pkg::SC_SUM) begin
            r_q <= total[cdp_pkg::FULL_W-1:cdp_pkg::FRAC_SH];
        end
        // magnitude stays below 2^43, so the score itself never clips
        if (load_out) begin
            if (r_norm == '0) begin
                r_score <= '0;
                r_sat   <= 1'b0;
            end else begin
                r_score <= r_neg ? -q_ext : q_ext;
                r_sat   <= r_clip;
            end
        end
    end

    assign o_tvalid    = r_out_valid;
    assign o_score     = r_score;
    assign o_saturated = r_sat;
    assign o_done      = load_out;

endmodule

### test/codebook_dot_product_unit_test.sv
module codebook_dot_product_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // run limits and pacing
    localparam int  CYCLE_LIMIT    = 200_000;
    localparam int  SETTLE_CYCLES  = 12;      // margin for the score latency plus the tready hold-off
    localparam int  LANE_COUNT     = cdp_pkg::DEFAULT_LANES;
    localparam int  RANDOM_PHASES  = 8;
    localparam int  PHASE_GROUPS   = 110;     // at least this many random groups per phase, clip vectors aside
    localparam int  CLIP_LENGTH    = 140;     // enough extreme groups to overrun 40 bits
    localparam int  AFTER_RESET_ROWS = 2;     // leading rows that run on the reset codebook
    localparam int  DIRECTED_ROWS  = 15;
    localparam int  REG_CENTROID_0 = 0;       // centroid_i sits at register REG_CENTROID_0 + i

    localparam longint     ACC_HI   = 64'sd549755813887;
    localparam longint     ACC_LO   = -ACC_HI - 64'sd1;
    localparam logic [63:0] SCORE_HI = 64'h0000_7FFF_FFFF_FFFF;

    // one element group as it travels on the slave side
    typedef struct packed {
        logic              final_group;
        logic [31:0]       key_norm;
        logic [3:0]        plane_high;
        logic [3:0]        plane_mid;
        logic [3:0]        plane_low;
        logic [3:0][15:0]  query;       // query[0] is query_a
    } t_group;

    typedef struct packed {
        logic [47:0] score;
        logic        sat;
    } t_score;

    // a directed row: the group, and a typed-in score where one is obvious
    typedef struct packed {
        t_group g;
        logic   typed;
        t_score want;
    } t_dir_row;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    // config port
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [cdp_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [cdp_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [cdp_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // group stream in
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [cdp_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                           s_axis_tlast  = 1'b0;

    // score stream out
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [cdp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]                     m_axis_tuser;

    codebook_dot_product_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor state: codebook, running Q11.29 sum and the clip flag
    cdp_pkg::t_codebook codebook_q = '{default: '0};
    longint    acc_q      = 0;
    bit        clip_q     = 1'b0;

    t_score pending_scores[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int groups_sent    = 0;
    int scores_checked = 0;
    int clip_scores    = 0;
    int cycle_count    = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // runs one group through the predictor; returns 1 when it closes a vector
    function automatic bit score_group(input t_group g, output t_score r);
        longint      sum;
        logic [2:0]  idx;
        logic [63:0] mag;
        logic [63:0] q;
        logic [127:0] wide;
        bit          neg;
        sum = acc_q;
        for (int k = 0; k < LANE_COUNT && k < cdp_pkg::FIELD_LANES; k++) begin
            idx = {g.plane_high[k], g.plane_mid[k], g.plane_low[k]};
            sum += longint'($signed(g.query[k])) * longint'(codebook_q[idx]);
        end
        // accumulator saturates and remembers it
        if (sum > ACC_HI) begin
            sum    = ACC_HI;
            clip_q = 1'b1;
        end else if (sum < ACC_LO) begin
            sum    = ACC_LO;
            clip_q = 1'b1;
        end
        acc_q = sum;
        r     = '0;
        if (!g.final_group)
            return 1'b0;
        if (g.key_norm != 0) begin
            // magnitude rounded half away from zero, then the sign
            neg   = acc_q < 0;
            mag   = neg ? 64'(-acc_q) : 64'(acc_q);
            wide  = {64'd0, mag} * {96'd0, g.key_norm} + (128'd1 << 28);
            q     = 64'(wide >> 29);
            r.sat = clip_q;
            if (!neg) begin
                if (q > SCORE_HI) begin
                    q     = SCORE_HI;
                    r.sat = 1'b1;
                end
                r.score = q[47:0];
            end else begin
                if (q > SCORE_HI + 64'd1) begin
                    q     = SCORE_HI + 64'd1;
                    r.sat = 1'b1;
                end
                r.score = 48'(-q);
            end
        end
        // zero norm leaves score and flag at zero
        acc_q  = 0;
        clip_q = 1'b0;
        return 1'b1;
    endfunction

    // one register write: setup cycle, then access until pready
    task automatic write_centroid(input int index, input logic [15:0] level);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= cdp_pkg::APB_ADDR_W'((REG_CENTROID_0 + index) * 4);
        pwdata  <= {{16{level[15]}}, level};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        codebook_q[index] = level;
    endtask

    // back to back writes, bus released after the last one
    task automatic load_codebook(input cdp_pkg::t_codebook levels);
        for (int i = 0; i < cdp_pkg::CB_ENTRIES; i++)
            write_centroid(i, levels[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offers one group, waits for the transfer, then logs the expected score of a closed vector
    task automatic push_group(input t_group g, input bit typed, input t_score want);
        t_score predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, g.key_norm, g.plane_high, g.plane_mid, g.plane_low, g.query};
        s_axis_tlast  <= g.final_group;
        // tvalid and tready are stable mid-cycle, so the next edge is the transfer
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        groups_sent++;
        if (score_group(g, predicted)) begin
            pending_scores.push_back(typed ? want : predicted);
            if (predicted.sat)
                clip_scores++;
        end
    endtask

    // drop tvalid, let every score come back and the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_level();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_group rand_group(input bit last);
        t_group g;
        for (int k = 0; k < cdp_pkg::FIELD_LANES; k++)
            g.query[k] = rand_level();
        g.plane_low   = 4'($urandom);
        g.plane_mid   = 4'($urandom);
        g.plane_high  = 4'($urandom);
        g.final_group = last;
        g.key_norm    = $urandom;
        if (last) begin
            case ($urandom_range(0, 7))
                0: g.key_norm = '0;
                1: g.key_norm = '1;
                2: g.key_norm = 32'($urandom_range(1, 65535));
                default: ;
            endcase
        end
        return g;
    endfunction

    function automatic t_dir_row mk_row(
        input logic [15:0] qa, qb, qc, qd,
        input logic [3:0]  pl, pm, ph,
        input logic [31:0] norm,
        input bit          last,
        input bit          typed,
        input logic [47:0] score,
        input bit          sat
    );
        t_dir_row r;
        r.g.query       = {qd, qc, qb, qa};
        r.g.plane_low   = pl;
        r.g.plane_mid   = pm;
        r.g.plane_high  = ph;
        r.g.key_norm    = norm;
        r.g.final_group = last;
        r.typed         = typed;
        r.want.score    = score;
        r.want.sat      = sat;
        return r;
    endfunction

    // receiver: random stalls, one nonblocking update per edge
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // score checker: sampled mid-cycle, a valid and ready pair transfers at the next edge
    always @(negedge i_clk) begin
        t_score exp_score;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_scores.size() == 0) begin
                report_mismatch($sformatf("score %h with nothing expected", m_axis_tdata));
            end else begin
                exp_score = pending_scores.pop_front();
                scores_checked++;
                if (m_axis_tdata !== exp_score.score)
                    report_mismatch($sformatf("score %h, expected %h",
                                              m_axis_tdata, exp_score.score));
                if (m_axis_tuser[0] !== exp_score.sat)
                    report_mismatch($sformatf("saturated %b, expected %b",
                                              m_axis_tuser[0], exp_score.sat));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d scores outstanding",
                     cycle_count, pending_scores.size());
            $display("codebook_dot_product_unit_test: FAIL");
            $finish;
        end
    end

    initial begin
        t_dir_row  rows [DIRECTED_ROWS];
        cdp_pkg::t_codebook levels;
        t_group    g;
        t_score    none;
        logic [15:0] clip_query;
        int        phase_count;
        int        vec_len;

        none = '0;

        // index:  0       1      2      3       4  5   6  7
        levels = '{16'h8000, 16'h7FFF, 16'h4000, 16'hC000,
                   16'h0001, 16'hFFFF, 16'h0000, 16'd12345};

        // reset codebook first, then the directed codebook above
        rows = '{
            // all products zero on the reset codebook, full norm and zero norm
            mk_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'hF, 4'hF, 4'hF,
                   32'hFFFF_FFFF, 1, 1, 48'd0, 0),
            mk_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'h0, 4'h0, 4'h0,
                   32'h0000_0000, 1, 1, 48'd0, 0),
            // -1.0 * -2.0 with unit norm: 2.0 in Q16.16
            mk_row(16'h8000, 16'h0000, 16'h0000, 16'h0000, 4'h0, 4'h0, 4'h0,
                   32'h0001_0000, 1, 1, 48'd131072, 0),
            mk_row(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 4'h1, 4'h0, 4'h0,
                   32'h0001_0000, 1, 0, 48'd0, 0),
            // exact half ties round away from zero, both signs
            mk_row(16'h0001, 16'h0000, 16'h0000, 16'h0000, 4'h0, 4'h0, 4'h1,
                   32'h1000_0000, 1, 1, 48'd1, 0),
            mk_row(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 4'h0, 4'h0, 4'h1,
                   32'h1000_0000, 1, 1, 48'hFFFF_FFFF_FFFF, 0),
            // just under the half rounds down
            mk_row(16'h0001, 16'h0000, 16'h0000, 16'h0000, 4'h0, 4'h0, 4'h1,
                   32'h0FFF_FFFF, 1, 1, 48'd0, 0),
            // three-group vector touching every codebook index
            mk_row(16'h03E8, 16'hF830, 16'h0BB8, 16'hF060, 4'hA, 4'hC, 4'h0,
                   32'h0000_0000, 0, 0, 48'd0, 0),
            mk_row(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 4'hA, 4'hC, 4'hF,
                   32'h0000_0000, 0, 0, 48'd0, 0),
            mk_row(16'h3039, 16'hCFC7, 16'h7FFF, 16'h8000, 4'h5, 4'h3, 4'h9,
                   32'hFFFF_FFFF, 1, 0, 48'd0, 0),
            // zero norm hides a large sum
            mk_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'h0, 4'h0, 4'h0,
                   32'h0000_0000, 1, 1, 48'd0, 0),
            // largest single-group sums, both signs, full norm
            mk_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'h0, 4'h0, 4'h0,
                   32'hFFFF_FFFF, 1, 0, 48'd0, 0),
            mk_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'hF, 4'h0, 4'h0,
                   32'hFFFF_FFFF, 1, 0, 48'd0, 0),
            // index 6 holds zero
            mk_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'h0, 4'hF, 4'hF,
                   32'h0001_0000, 1, 1, 48'd0, 0),
            mk_row(16'h0001, 16'h0001, 16'h0001, 16'h0001, 4'hF, 4'hF, 4'hF,
                   32'h0002_0000, 1, 0, 48'd0, 0)
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling on either side
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (i == AFTER_RESET_ROWS) begin
                settle();
                load_codebook(levels);
            end
            push_group(rows[i].g, rows[i].typed, rows[i].want);
        end

        // random part: each phase loads a new codebook and one of four idling patterns
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 57; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 57; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            for (int i = 0; i < cdp_pkg::CB_ENTRIES; i++) begin
                case (phase)
                    0:       levels[i] = 16'h8000;   // most negative everywhere
                    1:       levels[i] = 16'h7FFF;   // most positive everywhere
                    default: levels[i] = rand_level();
                endcase
            end
            load_codebook(levels);

            // long extreme vectors overrun the accumulator: positive, then negative
            if (phase < 2) begin
                clip_query = 16'h8000;
                for (int i = 0; i < CLIP_LENGTH; i++) begin
                    g       = rand_group(i == CLIP_LENGTH - 1);
                    g.query = {4{clip_query}};
                    // clipped sum with zero norm still reports no saturation
                    if (g.final_group)
                        g.key_norm = (phase == 1) ? 32'd0 : ($urandom | 32'd1);
                    push_group(g, 1'b0, none);
                end
            end

            phase_count = 0;
            while (phase_count < PHASE_GROUPS) begin
                vec_len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40)
                                                       : $urandom_range(1, 8);
                for (int i = 0; i < vec_len; i++)
                    push_group(rand_group(i == vec_len - 1), 1'b0, none);
                phase_count += vec_len;
            end
        end

        settle();

        $display("%0d groups sent over %0d random phases and the directed table",
                 groups_sent, RANDOM_PHASES);
        $display("%0d scores checked, %0d of them saturated, %0d mismatches",
                 scores_checked, clip_scores, mismatch_count);
        if (mismatch_count == 0 && pending_scores.size() == 0) begin
            $display("codebook_dot_product_unit_test: PASS");
        end else begin
            $display("codebook_dot_product_unit_test: FAIL");
        end
        $finish;
    end

endmodule

### files.f
src/cdp_pkg.sv
src/cdp_lane.sv
src/cdp_merge.sv
src/cdp_scale.sv
src/codebook_dot_product_unit.sv
test/codebook_dot_product_unit_test.sv
